### hw/rtl/first_fit_region_allocator_assert.svh
// Assertion macros for the first-fit region allocator.
// Used by the top level; expects aclk and aresetn in the including scope.
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FFRA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ffra: same-cycle check failed");
`define FFRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ffra: next-cycle check failed");
`else
`define FFRA_ASSERT_IMP(lbl, ante, cons)
`define FFRA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package ffra_pkg;

    localparam int REGIONS    = 32;
    localparam int HOLE_SLOTS = 16;
    localparam int PAGE_SHIFT = 8;
    localparam int PAGE_SIZE  = 1 << PAGE_SHIFT;

    localparam int ADDR_W = 32;
    localparam int ID_W   = 8;
    localparam int RIDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int HIDX_W = $clog2(HOLE_SLOTS);
    localparam int HCNT_W = $clog2(HOLE_SLOTS + 1);

    localparam logic [HCNT_W-1:0] HOLE_FULL = HCNT_W'(HOLE_SLOTS);
    localparam logic [ID_W:0]     ID_LIMIT  = (ID_W + 1)'(REGIONS);
    localparam logic [ADDR_W:0]   PAGE_ADD  = (ADDR_W + 1)'(PAGE_SIZE - 1);
    localparam logic [ADDR_W-1:0] PAGE_LOW  = ADDR_W'(PAGE_SIZE - 1);

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_RESOLVE = 2'd2,
        KIND_IGNORE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_OOB       = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   region_id;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] offset;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] address;
    } out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_NEXT,
        OP_FIT,
        OP_GROW,
        OP_FREE,
        OP_RESOLVE,
        OP_IGNORE,
        OP_BAD_ID
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic              id_bad;
        logic              scan_end;
        logic              fit;
        logic [HCNT_W-1:0] hole_cnt;
    } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ffra_datapath.sv
// Datapath of the first-fit region allocator: word register, region table,
// hole list, break pointer and result register. Depends on ffra_pkg.
`default_nettype none

module ffra_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ffra_pkg::in_t                  s_data,
    input  wire logic                           cfg_we,
    input  wire logic [ffra_pkg::ADDR_W-1:0]    cfg_wdata,
    input  wire ffra_pkg::dp_cmd_t              cmd,
    output ffra_pkg::dp_stat_t                  stat,
    output ffra_pkg::out_t                      m_data
);

    ffra_pkg::in_t                  item_reg;
    logic [ffra_pkg::HCNT_W-1:0]    scan_reg;
    logic [ffra_pkg::HCNT_W-1:0]    hcnt_reg;
    logic [ffra_pkg::ADDR_W-1:0]    brk_reg;
    logic [ffra_pkg::REGIONS-1:0]   rvalid_reg;
    logic [ffra_pkg::ADDR_W-1:0]    rd_start_reg;
    logic [ffra_pkg::ADDR_W-1:0]    rd_end_reg;
    logic                           rd_valid_reg;
    ffra_pkg::out_t                 out_reg;
    ffra_pkg::out_t                 out_next;

    logic [ffra_pkg::ADDR_W-1:0]    rs_mem [ffra_pkg::REGIONS];
    logic [ffra_pkg::ADDR_W-1:0]    re_mem [ffra_pkg::REGIONS];
    logic [ffra_pkg::ADDR_W-1:0]    hs_reg [ffra_pkg::HOLE_SLOTS];
    logic [ffra_pkg::ADDR_W-1:0]    he_reg [ffra_pkg::HOLE_SLOTS];

    logic [ffra_pkg::RIDX_W-1:0]    ridx;
    logic [ffra_pkg::HIDX_W-1:0]    hidx;
    logic [ffra_pkg::ADDR_W-1:0]    cur_s;
    logic [ffra_pkg::ADDR_W-1:0]    cur_e;
    logic [ffra_pkg::ADDR_W:0]      top;
    logic                           scan_end;
    logic                           fit;
    logic                           exact;
    logic [ffra_pkg::ADDR_W-1:0]    eff_s;
    logic [ffra_pkg::ADDR_W-1:0]    eff_e;
    logic [ffra_pkg::ADDR_W:0]      va;
    logic                           oob;
    logic [ffra_pkg::ADDR_W:0]      size_up;
    logic [ffra_pkg::ADDR_W-1:0]    grow_end;
    logic [ffra_pkg::ADDR_W-1:0]    grow_brk;
    ffra_pkg::status_t              free_status;
    logic                           push_do;
    logic                           free_ok;
    logic                           rwr;
    logic [ffra_pkg::ADDR_W-1:0]    rwr_s;
    logic [ffra_pkg::ADDR_W-1:0]    rwr_e;

    assign ridx = item_reg.region_id[ffra_pkg::RIDX_W-1:0];
    assign hidx = scan_reg[ffra_pkg::HIDX_W-1:0];

    assign cur_s    = hs_reg[hidx];
    assign cur_e    = he_reg[hidx];
    assign top      = {1'b0, cur_s} + {1'b0, item_reg.size};
    assign scan_end = (scan_reg >= hcnt_reg);
    assign fit      = !scan_end && (top <= {1'b0, cur_e});
    assign exact    = (top == {1'b0, cur_e});

    assign eff_s = rd_valid_reg ? rd_start_reg : '0;
    assign eff_e = rd_valid_reg ? rd_end_reg : '0;
    assign va    = {1'b0, eff_s} + {1'b0, item_reg.offset};
    assign oob   = (va >= {1'b0, eff_e});

    assign size_up  = {1'b0, item_reg.size} + ffra_pkg::PAGE_ADD;
    assign grow_end = brk_reg + item_reg.size;
    assign grow_brk = brk_reg + (size_up[ffra_pkg::ADDR_W-1:0] & ~ffra_pkg::PAGE_LOW);

    always_comb begin
        if (eff_s == '0 && eff_e == '0) begin
            free_status = ffra_pkg::ST_NOT_ALLOC;
        end else if (eff_s < eff_e && hcnt_reg == ffra_pkg::HOLE_FULL) begin
            free_status = ffra_pkg::ST_FULL;
        end else begin
            free_status = ffra_pkg::ST_OK;
        end
    end

    assign free_ok = (cmd.op == ffra_pkg::OP_FREE) && (free_status == ffra_pkg::ST_OK);
    assign push_do = free_ok && (eff_s < eff_e);

    assign rwr   = (cmd.op == ffra_pkg::OP_FIT) || (cmd.op == ffra_pkg::OP_GROW);
    assign rwr_s = (cmd.op == ffra_pkg::OP_FIT) ? cur_s : brk_reg;
    assign rwr_e = (cmd.op == ffra_pkg::OP_FIT) ? top[ffra_pkg::ADDR_W-1:0] : grow_end;

    always_comb begin
        out_next = out_reg;
        unique case (cmd.op)
            ffra_pkg::OP_FIT:     out_next = '{ffra_pkg::ST_OK, cur_s};
            ffra_pkg::OP_GROW:    out_next = '{ffra_pkg::ST_OK, brk_reg};
            ffra_pkg::OP_FREE:    out_next = '{free_status, '0};
            ffra_pkg::OP_RESOLVE: begin
                if (oob) begin
                    out_next = '{ffra_pkg::ST_OOB, '0};
                end else begin
                    out_next = '{ffra_pkg::ST_OK, va[ffra_pkg::ADDR_W-1:0]};
                end
            end
            ffra_pkg::OP_IGNORE:  out_next = '{ffra_pkg::ST_OK, '0};
            ffra_pkg::OP_BAD_ID:  out_next = '{ffra_pkg::ST_BAD_ID, '0};
            default:              out_next = out_reg;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg   <= '0;
            hcnt_reg   <= '0;
            brk_reg    <= '0;
            rvalid_reg <= '0;
        end else begin
            if (cfg_we) begin
                brk_reg <= cfg_wdata;
            end else if (cmd.op == ffra_pkg::OP_GROW) begin
                brk_reg <= grow_brk;
            end
            if (cmd.op == ffra_pkg::OP_LOAD) begin
                scan_reg <= '0;
            end else if (cmd.op == ffra_pkg::OP_NEXT) begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.op == ffra_pkg::OP_FIT && exact) begin
                hcnt_reg <= hcnt_reg - 1'b1;
            end else if (push_do) begin
                hcnt_reg <= hcnt_reg + 1'b1;
            end
            if (rwr) begin
                rvalid_reg[ridx] <= 1'b1;
            end else if (free_ok) begin
                rvalid_reg[ridx] <= 1'b0;
            end
        end
    end

    // region table
    always_ff @(posedge aclk) begin
        if (rwr) begin
            rs_mem[ridx] <= rwr_s;
            re_mem[ridx] <= rwr_e;
        end
        if (cmd.op == ffra_pkg::OP_READ) begin
            rd_start_reg <= rs_mem[ridx];
            rd_end_reg   <= re_mem[ridx];
            rd_valid_reg <= rvalid_reg[ridx];
        end
    end

    // hole list: shrink, drop with compaction, push at head
    always_ff @(posedge aclk) begin
        if (cmd.op == ffra_pkg::OP_FIT) begin
            if (exact) begin
                for (int k = 0; k < ffra_pkg::HOLE_SLOTS - 1; k++) begin
                    if (k >= int'(hidx)) begin
                        hs_reg[k] <= hs_reg[k + 1];
                        he_reg[k] <= he_reg[k + 1];
                    end
                end
            end else begin
                hs_reg[hidx] <= top[ffra_pkg::ADDR_W-1:0];
            end
        end else if (push_do) begin
            for (int k = 1; k < ffra_pkg::HOLE_SLOTS; k++) begin
                hs_reg[k] <= hs_reg[k - 1];
                he_reg[k] <= he_reg[k - 1];
            end
            hs_reg[0] <= eff_s;
            he_reg[0] <= eff_e;
        end
    end

    // word and result registers
    always_ff @(posedge aclk) begin
        if (cmd.op == ffra_pkg::OP_LOAD) begin
            item_reg <= s_data;
        end
        out_reg <= out_next;
    end

    assign stat.kind     = item_reg.kind;
    assign stat.id_bad   = ({1'b0, item_reg.region_id} >= ffra_pkg::ID_LIMIT);
    assign stat.scan_end = scan_end;
    assign stat.fit      = fit;
    assign stat.hole_cnt = hcnt_reg;

    assign m_data = out_reg;

endmodule

`default_nettype wire

### hw/rtl/ffra_ctrl.sv
// Controller of the first-fit region allocator: handshakes and the
// sequencing of datapath commands. Depends on ffra_pkg.
`default_nettype none

module ffra_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire ffra_pkg::dp_stat_t stat,
    output ffra_pkg::dp_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;
    logic   result;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd.op     = ffra_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = ffra_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.kind == ffra_pkg::KIND_IGNORE) begin
                    if (out_free) begin
                        cmd.op     = ffra_pkg::OP_IGNORE;
                        state_next = S_IDLE;
                    end
                end else if (stat.id_bad) begin
                    if (out_free) begin
                        cmd.op     = ffra_pkg::OP_BAD_ID;
                        state_next = S_IDLE;
                    end
                end else if (stat.kind == ffra_pkg::KIND_ALLOC) begin
                    state_next = S_SCAN;
                end else begin
                    cmd.op     = ffra_pkg::OP_READ;
                    state_next = S_EXEC;
                end
            end
            S_SCAN: begin
                if (stat.fit) begin
                    if (out_free) begin
                        cmd.op     = ffra_pkg::OP_FIT;
                        state_next = S_IDLE;
                    end
                end else if (stat.scan_end) begin
                    if (out_free) begin
                        cmd.op     = ffra_pkg::OP_GROW;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.op = ffra_pkg::OP_NEXT;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.op     = (stat.kind == ffra_pkg::KIND_FREE) ? ffra_pkg::OP_FREE
                                                                    : ffra_pkg::OP_RESOLVE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign result = cmd.op inside {ffra_pkg::OP_FIT, ffra_pkg::OP_GROW, ffra_pkg::OP_FREE,
                                   ffra_pkg::OP_RESOLVE, ffra_pkg::OP_IGNORE,
                                   ffra_pkg::OP_BAD_ID};

    assign m_valid_next = result || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### hw/rtl/first_fit_region_allocator.sv
// First-fit region allocator: allocate, free and resolve over a region table
// with an ordered hole list. Depends on ffra_pkg, ffra_ctrl, ffra_datapath.
//
// Input words (s_valid/s_ready, s_data) carry kind, region_id, size, offset.
// Each accepted word gives exactly one result word (m_valid/m_ready, m_data)
// with status and address, in order.
// Steps per word: ignored kind or bad id are answered from decode; free and
// resolve read the region table, then execute; allocate tests up to HOLE_SLOTS
// holes, grows at the break pointer if none fits. The hole scan tests one
// list entry per cycle against one adder; one word is in work at a time.
// Results land in an output register: a new word is accepted while the
// previous result still waits. A stalled receiver holds the result and
// the next word finishes its work and then waits for the register to drain.
// cfg_we/cfg_wdata load the heap base into the break pointer; write only
// while idle. Reset (aresetn low, synchronous) empties the region table
// through per-entry valid bits, empties the hole list and sets the break
// pointer to zero; no clearing pass, the block is ready right after reset.
`default_nettype none
`include "first_fit_region_allocator_assert.svh"

module first_fit_region_allocator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire ffra_pkg::in_t               s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output ffra_pkg::out_t                   m_data,
    input  wire logic                        cfg_we,
    input  wire logic [ffra_pkg::ADDR_W-1:0] cfg_wdata
);

    ffra_pkg::dp_cmd_t  cmd;
    ffra_pkg::dp_stat_t stat;

    ffra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ffra_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

    `FFRA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `FFRA_ASSERT_IMP(a_hole_bound, 1'b1, stat.hole_cnt <= ffra_pkg::HOLE_FULL)
    `FFRA_ASSERT_IMP(a_no_result_overwrite, m_valid && !m_ready, !(cmd.op == ffra_pkg::OP_FIT || cmd.op == ffra_pkg::OP_GROW || cmd.op == ffra_pkg::OP_FREE || cmd.op == ffra_pkg::OP_RESOLVE || cmd.op == ffra_pkg::OP_IGNORE || cmd.op == ffra_pkg::OP_BAD_ID))
    `FFRA_ASSERT_IMP(a_fit_in_list, cmd.op == ffra_pkg::OP_FIT, stat.fit && !stat.scan_end)

endmodule

`default_nettype wire
